@@ rtl/rbpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rbpe_pkg
// Shared constants and types of the Rice bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpe_pkg;

	// bits moved into the word buffer per cycle at most
	localparam int DIGIT_BITS    = 4;
	localparam int DIG_CNT_BITS  = $clog2(DIGIT_BITS + 1);

	localparam int K_BITS        = 5;
	// zero stop bit followed by up to 2**K_BITS-1 remainder bits
	localparam int TAIL_BITS     = 2 ** K_BITS;
	localparam int TAIL_CNT_BITS = K_BITS + 1;

	localparam int OUT_BITS      = 32;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	typedef struct packed {
		logic                     flush;
		logic                     ovf;
		logic [TAIL_CNT_BITS-1:0] tail_len;
		logic [TAIL_BITS-1:0]     tail;      // stop bit and remainder, first bit at MSB
	} job_t;

endpackage

`default_nettype wire

@@ rtl/rbpe_in_if.sv @@
// ----------------------------------------------------------------------------
// rbpe_in_if
// Sample channel: encode or flush command with sample and Rice parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbpe_in_if
	import rbpe_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic [K_BITS-1:0]             rice_k;

	modport source (output valid, func, sample_value, rice_k, input ready);
	modport sink   (input valid, func, sample_value, rice_k, output ready);
endinterface

`default_nettype wire

@@ rtl/rbpe_out_if.sv @@
// ----------------------------------------------------------------------------
// rbpe_out_if
// Word channel: packed words with last and overflow marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbpe_out_if
	import rbpe_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] packed_word;
	logic                last;
	logic                overflow_error;

	modport source (output valid, packed_word, last, overflow_error, input ready);
	modport sink   (input valid, packed_word, last, overflow_error, output ready);
endinterface

`default_nettype wire

@@ rtl/rice_bit_packer_encoder.sv @@
// ----------------------------------------------------------------------------
// rice_bit_packer_encoder
// Zigzag Rice encoder that packs code bits LSB first into words.
//
// samples: func selects encode (sample_value with parameter rice_k) or flush.
// words:   packed_word with last on the final word an item causes, and
//          overflow_error (word zero, nothing written) when the quotient
//          exceeds MAX_QUOTIENT.
// A sample enters a register stage (mapping, quotient, bound check) and the
// packer takes it from there when idle, then shifts up to 4 code bits per
// cycle while no full word waits, ones and stop/remainder bits in separate
// cycles. For an encode the packer shifts the ones and then the stop and
// remainder bits, sending each full word and finishing a split digit in
// between; a flush pads to a full word and sends it; an overflow sends a zero word.
// The prep stage takes the next item while the packer works on one.
// An encode that completes no word past its end sends nothing.
// Reset empties the word buffer and drops any undelivered word.
// When words stalls, the held word waits in the output register and the
// packer stops at the next word boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_bit_packer_encoder
	import rbpe_pkg::*;
#(
	parameter int WORD_BITS    = 32,
	parameter int MAX_QUOTIENT = 1024,
	parameter int SAMPLE_BITS  = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rbpe_in_if.sink   samples,
	rbpe_out_if.source words
);

	localparam int QW = $clog2(MAX_QUOTIENT + 1);

	logic          job_valid;
	logic          job_ready;
	job_t          job;
	logic [QW-1:0] job_ones;

	rbpe_prep #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_QUOTIENT (MAX_QUOTIENT)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.job_ones  (job_ones)
	);

	rbpe_packer #(
		.WORD_BITS    (WORD_BITS),
		.MAX_QUOTIENT (MAX_QUOTIENT)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.job_ones  (job_ones),
		.words     (words)
	);

`ifndef ASSERT_OFF
	a_ovf_word: assert property (@(posedge clk) disable iff (!arst_n)
		words.valid && words.overflow_error |-> words.last && words.packed_word == '0)
		else $error("overflow item not a single zero word");

	a_prep_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready
		|=> job_valid && (job.flush == $past(samples.func == FUNC_FLUSH)))
		else $error("accepted item not handed to packer");

	a_flush_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.flush |-> !job.ovf)
		else $error("flush item marked as overflow");
`endif

endmodule

`default_nettype wire

@@ rtl/rbpe_prep.sv @@
// ----------------------------------------------------------------------------
// rbpe_prep
// Zigzag mapping, quotient split and bound check; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpe_prep
	import rbpe_pkg::*;
#(
	parameter int  SAMPLE_BITS  = 24,
	parameter int  MAX_QUOTIENT = 1024,
	localparam int QW           = $clog2(MAX_QUOTIENT + 1)
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rbpe_in_if.sink      samples,
	output      logic    job_valid,
	input  wire logic    job_ready,
	output      job_t    job,
	output      logic [QW-1:0] job_ones
);

	logic [SAMPLE_BITS-1:0] u;
	logic [SAMPLE_BITS-1:0] q;
	logic [TAIL_BITS-1:0]   ux;
	logic [TAIL_BITS-1:0]   tail;
	logic                   ovf;
	logic                   take;

	logic                   job_valid_q;
	job_t                   job_q;
	logic [QW-1:0]          ones_q;

	assign take          = samples.valid && samples.ready;
	assign samples.ready = !job_valid_q || job_ready;

	always_comb begin
		// 2v for v >= 0, -2v-1 (= ~2v) for v < 0
		u    = {samples.sample_value[SAMPLE_BITS-2:0], 1'b0}
		       ^ {SAMPLE_BITS{samples.sample_value[SAMPLE_BITS-1]}};
		q    = u >> samples.rice_k;
		ovf  = 33'(q) > 33'(MAX_QUOTIENT);
		ux   = TAIL_BITS'(u);
		// left-align the k remainder bits just below the stop bit
		tail = ux << (K_BITS'(TAIL_BITS - 1) - samples.rice_k);
		tail[TAIL_BITS-1] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (take) begin
			job_valid_q <= 1'b1;
		end else if (job_ready) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q.flush    <= (samples.func == FUNC_FLUSH);
			job_q.ovf      <= (samples.func == FUNC_ENCODE) && ovf;
			job_q.tail_len <= TAIL_CNT_BITS'(samples.rice_k) + TAIL_CNT_BITS'(1);
			job_q.tail     <= tail;
			ones_q         <= QW'(q);
		end
	end

	assign job_valid = job_valid_q;
	assign job       = job_q;
	assign job_ones  = ones_q;

endmodule

`default_nettype wire

@@ rtl/rbpe_packer.sv @@
// ----------------------------------------------------------------------------
// rbpe_packer
// Digit-serial word buffer: shifts up to DIGIT_BITS code bits per cycle while
// no full word waits, into a right-shifting word register feeding the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpe_packer
	import rbpe_pkg::*;
#(
	parameter int  WORD_BITS    = 32,
	parameter int  MAX_QUOTIENT = 1024,
	localparam int QW           = $clog2(MAX_QUOTIENT + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output      logic          job_ready,
	input  wire job_t          job,
	input  wire logic [QW-1:0] job_ones,
	rbpe_out_if.source         words
);

	localparam int CW = $clog2(WORD_BITS + 1);
	localparam int NW = DIG_CNT_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CODE,
		S_FLUSH,
		S_OVF
	} state_t;

	state_t                   state_q;
	logic [WORD_BITS-1:0]     buf_q;
	logic [CW-1:0]            cnt_q;
	logic [QW-1:0]            ones_q;
	logic [TAIL_BITS-1:0]     tail_q;
	logic [TAIL_CNT_BITS-1:0] tail_left_q;
	logic                     out_valid_q;
	logic [OUT_BITS-1:0]      word_q;
	logic                     last_q;
	logic                     ovf_q;

	logic [CW-1:0]            avail;
	logic                     full;
	logic                     out_free;
	logic                     load_word;
	logic [NW-1:0]            n;
	logic [DIGIT_BITS-1:0]    dig;
	logic                     from_tail;
	logic [WORD_BITS-1:0]     shifted;
	logic                     last_word;
	logic                     code_done;

	always_comb begin
		avail     = CW'(WORD_BITS) - cnt_q;
		full      = (cnt_q == CW'(WORD_BITS));
		out_free  = !out_valid_q || words.ready;
		load_word = out_free && ((full && (state_q == S_CODE || state_q == S_FLUSH)) ||
		                         (state_q == S_OVF));
		n         = NW'(DIGIT_BITS);
		dig       = '0;
		from_tail = 1'b0;
		if (state_q == S_CODE) begin
			if (ones_q != '0) begin
				dig = '1;
				if (32'(ones_q) < DIGIT_BITS) n = NW'(ones_q);
			end else begin
				from_tail = 1'b1;
				for (int i = 0; i < DIGIT_BITS; i++) dig[i] = tail_q[TAIL_BITS-1-i];
				if (32'(tail_left_q) < DIGIT_BITS) n = NW'(tail_left_q);
			end
		end
		if (32'(avail) < 32'(n)) n = NW'(avail);

		// new bits enter at the top; earliest bit ends up lowest
		shifted = buf_q;
		for (int s = 1; s <= DIGIT_BITS; s++) begin
			if (n == NW'(s)) begin
				shifted = buf_q >> s;
				for (int i = 0; i < s; i++) shifted[WORD_BITS-s+i] = dig[i];
			end
		end

		// the rest of the code fits in the fresh word: no further word from it
		last_word = (32'(ones_q) + 32'(tail_left_q)) <= WORD_BITS;
		code_done = from_tail && (tail_left_q == TAIL_CNT_BITS'(n));
	end

	assign job_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			buf_q       <= '0;
			cnt_q       <= '0;
			ones_q      <= '0;
			tail_q      <= '0;
			tail_left_q <= '0;
			word_q      <= '0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (load_word) begin
				out_valid_q <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						ones_q      <= job_ones;
						tail_q      <= job.tail;
						tail_left_q <= job.tail_len;
						priority if (job.flush) begin
							state_q <= S_FLUSH;
						end else if (job.ovf) begin
							state_q <= S_OVF;
						end else begin
							state_q <= S_CODE;
						end
					end
				end
				S_CODE: begin
					if (full) begin
						if (out_free) begin
							word_q      <= OUT_BITS'(buf_q);
							last_q      <= last_word;
							ovf_q       <= 1'b0;
							cnt_q       <= '0;
						end
					end else begin
						buf_q <= shifted;
						cnt_q <= cnt_q + CW'(n);
						if (from_tail) begin
							tail_q      <= tail_q << n;
							tail_left_q <= tail_left_q - TAIL_CNT_BITS'(n);
							if (code_done) state_q <= S_IDLE;
						end else begin
							ones_q <= ones_q - QW'(n);
						end
					end
				end
				S_FLUSH: begin
					if (full) begin
						if (out_free) begin
							word_q      <= OUT_BITS'(buf_q);
							last_q      <= 1'b1;
							ovf_q       <= 1'b0;
							cnt_q       <= '0;
							state_q     <= S_IDLE;
						end
					end else begin
						// pad with zeros until the pending bits sit at the bottom
						buf_q <= shifted;
						cnt_q <= cnt_q + CW'(n);
					end
				end
				S_OVF: begin
					if (out_free) begin
						word_q      <= '0;
						last_q      <= 1'b1;
						ovf_q       <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign words.valid          = out_valid_q;
	assign words.packed_word    = word_q;
	assign words.last           = last_q;
	assign words.overflow_error = ovf_q;

endmodule

`default_nettype wire

@@ tb/tb_rice_bit_packer_encoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rice_bit_packer_encoder
// Self-checking bench for the zigzag Rice bit packer. A scoreboard keeps its
// own word buffer, predicts the packed words of every accepted item and
// checks each delivered word in order. Directed corner items are followed by
// random traffic under varying idle rates on both channels, including one
// long receiver hold-off.
// ----------------------------------------------------------------------------

class rice_scoreboard;
	typedef struct {
		bit [31:0] word;
		bit        last;
		bit        ovf;
	} word_t;

	localparam int MAX_Q = 1024;

	word_t       expected_words[$];
	bit [31:0]   pend_bits;
	int unsigned pend_cnt;
	int unsigned errors;

	function new();
		pend_bits = '0;
		pend_cnt  = 0;
		errors    = 0;
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	// a full word leaves only when the next bit shows up
	function void push_code_bit(bit b);
		word_t w;
		if (pend_cnt >= 32) begin
			w.word = pend_bits;
			w.last = 1'b0;
			w.ovf  = 1'b0;
			expected_words.push_back(w);
			pend_bits = '0;
			pend_cnt  = 0;
		end
		pend_bits[pend_cnt] = b;
		pend_cnt++;
	endfunction

	function void note_input(logic f, logic signed [23:0] s, logic [4:0] k);
		word_t     w;
		int        v;
		bit [31:0] u;
		bit [31:0] q;
		int        n0;
		n0 = expected_words.size();
		if (f == rbpe_pkg::FUNC_FLUSH) begin
			w.word = pend_bits;
			w.last = 1'b1;
			w.ovf  = 1'b0;
			expected_words.push_back(w);
			pend_bits = '0;
			pend_cnt  = 0;
			return;
		end
		v = s;
		u = (v < 0) ? -2 * v - 1 : 2 * v;
		q = u >> k;
		if (q > MAX_Q) begin
			w.word = '0;
			w.last = 1'b1;
			w.ovf  = 1'b1;
			expected_words.push_back(w);
			return;
		end
		repeat (q) push_code_bit(1'b1);
		push_code_bit(1'b0);
		for (int i = k; i > 0; i--)
			push_code_bit(u[i-1]);
		if (expected_words.size() > n0)
			expected_words[expected_words.size()-1].last = 1'b1;
	endfunction

	function void check_word(logic [31:0] word, logic last, logic ovf);
		word_t w;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word %h last %b ovf %b", $time, word, last, ovf);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (word !== w.word) begin
			$display("%0t: packed_word expected %h actual %h", $time, w.word, word);
			errors++;
		end
		if (last !== w.last) begin
			$display("%0t: last expected %b actual %b", $time, w.last, last);
			errors++;
		end
		if (ovf !== w.ovf) begin
			$display("%0t: overflow_error expected %b actual %b", $time, w.ovf, ovf);
			errors++;
		end
	endfunction
endclass

module tb_rice_bit_packer_encoder
	import rbpe_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 100;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic hold_req;
	int   stuck_cycles;

	rice_scoreboard sb;

	rbpe_in_if #(.SAMPLE_BITS(24)) samples_if ();
	rbpe_out_if                    words_if ();

	rice_bit_packer_encoder #(
		.WORD_BITS   (32),
		.MAX_QUOTIENT(1024),
		.SAMPLE_BITS (24)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.words  (words_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random ready, plus one long hold-off on request
	initial begin
		int hold_cnt;
		bit hold_done;
		hold_cnt  = 0;
		hold_done = 1'b0;
		words_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt  = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				words_if.ready <= 1'b0;
			end else begin
				words_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && samples_if.valid && samples_if.ready)
			sb.note_input(samples_if.func, samples_if.sample_value, samples_if.rice_k);
		if (arst_n && words_if.valid && words_if.ready)
			sb.check_word(words_if.packed_word, words_if.last, words_if.overflow_error);
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready) ||
		    (words_if.valid && words_if.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_item(input logic f, input logic [23:0] s, input logic [4:0] k);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid        <= 1'b1;
		samples_if.func         <= f;
		samples_if.sample_value <= s;
		samples_if.rice_k       <= k;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
	endtask

	// inverse zigzag: pick the mapped value, send the sample that yields it
	task automatic send_mapped(input logic [23:0] u, input logic [4:0] k);
		logic [23:0] s;
		s = u[0] ? -((u >> 1) + 24'd1) : (u >> 1);
		send_item(FUNC_ENCODE, s, k);
	endtask

	task automatic send_random();
		int          r;
		logic [4:0]  k;
		logic [31:0] u;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			send_item(FUNC_FLUSH, 24'($urandom), 5'($urandom));
		end else if (r < 14) begin
			send_item(FUNC_ENCODE, 24'($urandom), 5'($urandom));
		end else if (r < 18) begin
			// long unary runs around the quotient bound
			k = 5'($urandom_range(0, 3));
			u = ($urandom_range(900, 1030) << k) | ($urandom & ((32'd1 << k) - 1));
			send_mapped(u[23:0], k);
		end else begin
			k = 5'($urandom_range(0, 31));
			u = ($urandom_range(0, 12) << k) | ($urandom & ((32'd1 << k) - 1));
			send_mapped(u[23:0], k);
		end
	endtask

	initial begin
		sb = new();
		tx_idle_pct  = 18;
		rx_idle_pct  = 64;
		hold_req     <= 1'b0;
		arst_n       <= 1'b0;
		samples_if.valid        <= 1'b0;
		samples_if.func         <= FUNC_ENCODE;
		samples_if.sample_value <= '0;
		samples_if.rice_k       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_FLUSH, 24'd0, 5'd0);              // empty word
		send_item(FUNC_ENCODE, 24'd0, 5'd0);
		send_item(FUNC_ENCODE, 24'd1, 5'd0);
		send_item(FUNC_ENCODE, -24'sd1, 5'd0);
		send_item(FUNC_ENCODE, 24'h7FFFFF, 5'd23);
		send_item(FUNC_ENCODE, 24'h800000, 5'd23);
		send_item(FUNC_ENCODE, 24'h800000, 5'd31);       // remainder above sample width
		send_item(FUNC_ENCODE, 24'h7FFFFF, 5'd24);
		send_item(FUNC_ENCODE, 24'd5, 5'd31);
		send_item(FUNC_ENCODE, 24'd512, 5'd0);           // quotient right at the bound
		send_item(FUNC_ENCODE, -24'sd513, 5'd0);         // one past the bound
		send_item(FUNC_ENCODE, 24'h7FFFFF, 5'd0);
		send_item(FUNC_ENCODE, 24'h800000, 5'd1);
		send_item(FUNC_FLUSH, 24'hFFFFFF, 5'd31);
		send_item(FUNC_FLUSH, 24'd0, 5'd0);
		// exactly one word worth of bits, then flush it
		send_item(FUNC_ENCODE, 24'h800000, 5'd31);
		send_item(FUNC_FLUSH, 24'd0, 5'd0);
		// exactly full, then a further bit pushes it out
		send_item(FUNC_ENCODE, 24'h800000, 5'd31);
		send_item(FUNC_ENCODE, 24'd0, 5'd0);
		send_item(FUNC_ENCODE, 24'd255, 5'd4);
		send_item(FUNC_ENCODE, -24'sd1000, 5'd10);
		send_item(FUNC_ENCODE, 24'h2AAAAA, 5'd16);
		send_item(FUNC_ENCODE, 24'h555555, 5'd22);
		send_item(FUNC_FLUSH, 24'd0, 5'd0);

		repeat (150) send_random();
		tx_idle_pct = 64;
		rx_idle_pct = 18;
		repeat (150) send_random();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req <= 1'b1;
		repeat (160) send_random();
		samples_if.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/rbpe_pkg.sv
rtl/rbpe_in_if.sv
rtl/rbpe_out_if.sv
rtl/rbpe_prep.sv
rtl/rbpe_packer.sv
rtl/rice_bit_packer_encoder.sv
tb/tb_rice_bit_packer_encoder.sv
